FILE: rtl/core/dsru_pkg.sv
// shared types and constants of the divide and square-root register unit
`default_nettype none
package dsru_pkg;
  typedef enum logic [1:0] {
    K_PLAIN = 2'd0,
    K_DIV   = 2'd1,
    K_ROOT  = 2'd2
  } kind_t;

  typedef struct packed {
    logic       op;
    logic [5:0] off;
    logic [7:0] wbyte;
    kind_t      kind;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_PREP   = 3'd1,
    S_DIV    = 3'd2,
    S_DFIX   = 3'd3,
    S_ROOT   = 3'd4,
    S_ACCESS = 3'd5
  } bstate_t;

  localparam logic [5:0] OFF_QUO_LO  = 6'h20;
  localparam logic [5:0] OFF_REM_LO  = 6'h28;
  localparam logic [5:0] OFF_ROOT_LO = 6'h34;
  localparam logic [5:0] OFF_MODE    = 6'h30;
  localparam logic [15:0] DIV_ZERO_FLAG = 16'h4000;
endpackage
`default_nettype wire

FILE: rtl/core/dsru_front.sv
// front end: takes bus items, classifies them, holds them in a short queue
`default_nettype none
module dsru_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          op,
  input  wire logic [5:0]    byte_offset,
  input  wire logic [7:0]    write_byte,
  output logic               busy,
  output dsru_pkg::cmd_t     cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_take
);
  import dsru_pkg::*;

  cmd_t q [2];
  logic wp, rp;
  logic [1:0] cnt;
  cmd_t incoming;
  logic push, pop;

  always_comb begin
    incoming.op    = op;
    incoming.off   = byte_offset;
    incoming.wbyte = write_byte;
    incoming.kind  = K_PLAIN;
    if (!op && (byte_offset == OFF_QUO_LO || byte_offset == OFF_REM_LO)) begin
      incoming.kind = K_DIV;
    end else if (!op && byte_offset == OFF_ROOT_LO) begin
      incoming.kind = K_ROOT;
    end
  end

  assign busy      = (cnt == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (cnt != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/dsru_back.sv
// back end: register file, iterative divider and root, read data
`default_nettype none
module dsru_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  dsru_pkg::cmd_t     cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_take,
  output logic               done,
  output logic [7:0]         read_byte
);
  import dsru_pkg::*;

  logic [15:0] div_control;
  logic [63:0] dividend, divisor, quotient, remainder_value, root_operand;
  logic        root_mode;
  logic [31:0] root_result;

  bstate_t state, state_next;
  cmd_t    cur;

  // divider working registers
  logic [63:0] ua, ub, uq, ur;
  logic        na, qneg;
  logic [6:0]  cnt;
  logic [1:0]  mode;
  // root working registers
  logic [63:0] rx, rres, rbit;

  logic [63:0] a_sel, b_sel, min_sel;
  logic [64:0] ur_sh, ur_sub;
  logic [63:0] rsum;

  always_comb begin
    mode = div_control[1:0];
    if (mode == 2'd0) begin
      a_sel   = {{32{dividend[31]}}, dividend[31:0]};
      b_sel   = {{32{divisor[31]}}, divisor[31:0]};
      min_sel = {32'hFFFFFFFF, 32'h80000000};
    end else begin
      a_sel   = dividend;
      b_sel   = (mode == 2'd1) ? {{32{divisor[31]}}, divisor[31:0]} : divisor;
      min_sel = 64'h8000000000000000;
    end
    ur_sh  = {ur, ua[63]};
    ur_sub = ur_sh - {1'b0, ub};
    rsum   = rres + rbit;
  end

  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          unique case (cmd.kind)
            K_DIV:   state_next = S_PREP;
            K_ROOT:  state_next = S_ROOT;
            default: state_next = S_ACCESS;
          endcase
        end
      end
      S_PREP:   state_next = (mode == 2'd3 || b_sel == 64'd0 ||
                              (a_sel == min_sel && b_sel == '1)) ? S_ACCESS : S_DIV;
      S_DIV:    state_next = (cnt == 7'd63) ? S_DFIX : S_DIV;
      S_DFIX:   state_next = S_ACCESS;
      S_ROOT:   state_next = (rbit == 64'd0) ? S_ACCESS : S_ROOT;
      S_ACCESS: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_control <= '0; dividend <= '0; divisor <= '0; quotient <= '0;
      remainder_value <= '0; root_mode <= 1'b0; root_operand <= '0;
      root_result <= '0; done <= 1'b0; read_byte <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur  <= cmd;
            rx   <= cmd.kind == K_ROOT && !root_mode ?
                    {32'd0, root_operand[31:0]} : root_operand;
            rres <= '0;
            rbit <= 64'h4000000000000000;
          end
        end
        S_PREP: begin
          na   <= a_sel[63];
          qneg <= a_sel[63] ^ b_sel[63];
          ua   <= a_sel[63] ? -a_sel : a_sel;
          ub   <= b_sel[63] ? -b_sel : b_sel;
          ur   <= '0;
          uq   <= '0;
          cnt  <= '0;
          if (mode != 2'd3) begin
            if (b_sel == 64'd0) begin
              if (divisor == 64'd0) div_control <= div_control | DIV_ZERO_FLAG;
              remainder_value <= a_sel;
              if (mode == 2'd0)
                quotient <= a_sel[63] ? 64'hFFFFFFFF00000001 : 64'h00000000FFFFFFFF;
              else
                quotient <= a_sel[63] ? 64'd1 : '1;
            end else if (a_sel == min_sel && b_sel == '1) begin
              quotient <= (mode == 2'd0) ? 64'h0000000080000000 : 64'h8000000000000000;
              remainder_value <= '0;
            end
          end
        end
        S_DIV: begin
          // one quotient bit a cycle, restoring
          cnt <= cnt + 7'd1;
          ua  <= {ua[62:0], 1'b0};
          if (!ur_sub[64]) begin
            ur <= ur_sub[63:0];
            uq <= {uq[62:0], 1'b1};
          end else begin
            ur <= ur_sh[63:0];
            uq <= {uq[62:0], 1'b0};
          end
        end
        S_DFIX: begin
          quotient        <= qneg ? -uq : uq;
          remainder_value <= na ? -ur : ur;
        end
        S_ROOT: begin
          // one result bit pair a cycle
          if (rbit == 64'd0) begin
            root_result <= rres[31:0];
          end else begin
            if (rx >= rsum) begin
              rx   <= rx - rsum;
              rres <= (rres >> 1) + rbit;
            end else begin
              rres <= rres >> 1;
            end
            rbit <= rbit >> 2;
          end
        end
        S_ACCESS: begin
          done      <= 1'b1;
          read_byte <= '0;
          if (cur.op) begin
            priority if (cur.off <= 6'h01) begin
              div_control[cur.off[0]*8 +: 8] <= cur.wbyte;
            end else if (cur.off[5:3] == 3'd2) begin
              dividend[cur.off[2:0]*8 +: 8] <= cur.wbyte;
            end else if (cur.off[5:3] == 3'd3) begin
              divisor[cur.off[2:0]*8 +: 8] <= cur.wbyte;
            end else if (cur.off == OFF_MODE) begin
              root_mode <= cur.wbyte[0];
            end else if (cur.off[5:3] == 3'd7) begin
              root_operand[cur.off[2:0]*8 +: 8] <= cur.wbyte;
            end
          end else begin
            priority if (cur.off <= 6'h01) begin
              read_byte <= div_control[cur.off[0]*8 +: 8];
            end else if (cur.off[5:3] == 3'd2) begin
              read_byte <= dividend[cur.off[2:0]*8 +: 8];
            end else if (cur.off[5:3] == 3'd3) begin
              read_byte <= divisor[cur.off[2:0]*8 +: 8];
            end else if (cur.off[5:3] == 3'd4) begin
              read_byte <= quotient[cur.off[2:0]*8 +: 8];
            end else if (cur.off[5:3] == 3'd5) begin
              read_byte <= remainder_value[cur.off[2:0]*8 +: 8];
            end else if (cur.off == OFF_MODE) begin
              read_byte <= {7'd0, root_mode};
            end else if (cur.off[5:2] == 4'hD) begin
              read_byte <= root_result[cur.off[1:0]*8 +: 8];
            end else if (cur.off[5:3] == 3'd7) begin
              read_byte <= root_operand[cur.off[2:0]*8 +: 8];
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/divide_sqrt_register_unit.sv
// top level of the divide and square-root register unit
`default_nettype none
// Byte-wide register unit for signed integer division and floor square root.
// An item is one bus access (read or write) taken when start is high and
// busy is low; every item, write or read, gives exactly one result byte on
// read_byte, flagged by done for one cycle, and the receiver cannot stall it.
// A front stage classifies items into a two-entry queue; the back stage
// executes them one at a time. A read of the low quotient or remainder
// byte runs the divider, one quotient bit per cycle, unless the mode is
// hold, the divisor is zero or the quotient overflows; a read of the low
// root byte runs the root loop, two operand bits per cycle. busy rises only
// when the queue is full.
module divide_sqrt_register_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       op,
  input  wire logic [5:0] byte_offset,
  input  wire logic [7:0] write_byte,
  output logic            done,
  output logic [7:0]      read_byte
);
  import dsru_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;

  // item queue and classifier
  dsru_front u_front (
    .clk, .rst, .start, .op, .byte_offset, .write_byte,
    .busy, .cmd, .cmd_valid, .cmd_take
  );

  // execution: registers, divider, root
  dsru_back u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_take, .done, .read_byte
  );
endmodule
`default_nettype wire

FILE: dv/testbench.sv
// self-checking testbench of the divide and square-root register unit
`default_nettype none
module testbench;
  import dsru_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // bus access kinds of one item
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // register map, offsets from the unit base
  localparam logic [5:0] OFF_CTRL_LO = 6'h00;
  localparam logic [5:0] OFF_CTRL_HI = 6'h01;
  localparam logic [5:0] OFF_NUM     = 6'h10;
  localparam logic [5:0] OFF_DEN     = 6'h18;
  localparam logic [5:0] OFF_ROOT_OP = 6'h38;

  // division modes in the low control bits
  localparam logic [1:0] MODE_32   = 2'd0;
  localparam logic [1:0] MODE_64_32 = 2'd1;
  localparam logic [1:0] MODE_64   = 2'd2;
  localparam logic [1:0] MODE_HOLD = 2'd3;

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] HI32  = 64'hFFFF_FFFF_0000_0000;
  localparam logic [63:0] LO32  = 64'h0000_0000_FFFF_FFFF;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       op;
  logic [5:0] byte_offset;
  logic [7:0] write_byte;
  logic       done;
  logic [7:0] read_byte;

  divide_sqrt_register_unit dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .byte_offset (byte_offset),
    .write_byte  (write_byte),
    .done        (done),
    .read_byte   (read_byte)
  );

  // predicted register file of the unit
  logic [15:0] ctrl_q;
  logic [63:0] numer_q;
  logic [63:0] denom_q;
  logic [63:0] quot_q;
  logic [63:0] rem_q;
  logic        rmode_q;
  logic [63:0] rop_q;
  logic [31:0] root_q;

  logic [7:0] expected_bytes[$];
  int         error_count;
  int         send_idle_pct;   // chance of a gap before an item, in percent

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous fixed limit: over 2400 items plus gaps
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [63:0] sext32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  // signed truncating division with the unit's corner-case results
  function automatic void predict_division();
    logic [1:0]  mode;
    logic [63:0] a, b, minv, ua, ub, uq, ur;
    mode = ctrl_q[1:0];
    if (mode == MODE_HOLD) return;
    if (mode == MODE_32) begin
      a = sext32(numer_q);
      b = sext32(denom_q);
      minv = sext32(64'h8000_0000);
    end else begin
      a = numer_q;
      b = (mode == MODE_64_32) ? sext32(denom_q) : denom_q;
      minv = MIN64;
    end
    if (b == 64'd0) begin
      // divide by zero: flag only when the whole divisor is zero
      if (denom_q == 64'd0) ctrl_q = ctrl_q | DIV_ZERO_FLAG;
      rem_q = a;
      if (mode == MODE_32) quot_q = a[63] ? (HI32 | 64'd1) : LO32;
      else quot_q = a[63] ? 64'd1 : '1;
      return;
    end
    if (a == minv && b == '1) begin
      // most negative over minus one overflows
      quot_q = (mode == MODE_32) ? 64'h8000_0000 : MIN64;
      rem_q = 64'd0;
      return;
    end
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    uq = ua / ub;
    ur = ua % ub;
    quot_q = (a[63] != b[63]) ? -uq : uq;
    rem_q = a[63] ? -ur : ur;
  endfunction

  // bitwise floor square root
  function automatic void predict_root();
    logic [63:0] x, res, bitv;
    x = rmode_q ? rop_q : (rop_q & LO32);
    res = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    root_q = res[31:0];
  endfunction

  function automatic logic [63:0] put_byte(input logic [63:0] v, input logic [2:0] k,
                                           input logic [7:0] b);
    v[k*8 +: 8] = b;
    return v;
  endfunction

  // one bus access applied to the predicted registers; returns the byte read
  function automatic logic [7:0] predict_access(input logic acc, input logic [5:0] off,
                                                input logic [7:0] wb);
    logic [2:0] k;
    logic [63:0] v;
    k = off[2:0];
    if (acc == ACC_WRITE) begin
      if (off <= OFF_CTRL_HI) begin
        v = put_byte({48'd0, ctrl_q}, k, wb);
        ctrl_q = v[15:0];
      end else if (off >= OFF_NUM && off < OFF_DEN) numer_q = put_byte(numer_q, k, wb);
      else if (off >= OFF_DEN && off < OFF_QUO_LO) denom_q = put_byte(denom_q, k, wb);
      else if (off == OFF_MODE) rmode_q = wb[0];
      else if (off >= OFF_ROOT_OP) rop_q = put_byte(rop_q, k, wb);
      return 8'd0;
    end
    if (off <= OFF_CTRL_HI) return ctrl_q[k*8 +: 8];
    if (off >= OFF_NUM && off < OFF_DEN) return numer_q[k*8 +: 8];
    if (off >= OFF_DEN && off < OFF_QUO_LO) return denom_q[k*8 +: 8];
    if (off >= OFF_QUO_LO && off < OFF_REM_LO) begin
      if (off == OFF_QUO_LO) predict_division();
      return quot_q[k*8 +: 8];
    end
    if (off >= OFF_REM_LO && off < OFF_MODE) begin
      if (off == OFF_REM_LO) predict_division();
      return rem_q[k*8 +: 8];
    end
    if (off == OFF_MODE) return {7'd0, rmode_q};
    if (off >= OFF_ROOT_LO && off < OFF_ROOT_OP) begin
      if (off == OFF_ROOT_LO) predict_root();
      return root_q[(off - OFF_ROOT_LO)*8 +: 8];
    end
    if (off >= OFF_ROOT_OP) return rop_q[k*8 +: 8];
    return 8'd0;   // unmapped
  endfunction

  // send one item: optional random gap, then hold start until accepted
  task automatic send_access(input logic acc, input logic [5:0] off, input logic [7:0] wb);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    op          <= acc;
    byte_offset <= off;
    write_byte  <= wb;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge, so predict now in acceptance order
    expected_bytes.push_back(predict_access(acc, off, wb));
  endtask

  task automatic write_word(input logic [5:0] base, input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) send_access(ACC_WRITE, base + 6'(i), v[i*8 +: 8]);
  endtask

  task automatic read_word(input logic [5:0] base, input int n);
    for (int i = 0; i < n; i++) send_access(ACC_READ, base + 6'(i), 8'd0);
  endtask

  // park start and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // one division with given operands and mode, read both results fully
  task automatic run_divide(input logic [1:0] mode, input logic [63:0] a, input logic [63:0] b);
    write_word(OFF_NUM, a, 8);
    write_word(OFF_DEN, b, 8);
    send_access(ACC_WRITE, OFF_CTRL_LO, {6'($urandom), mode});
    read_word(OFF_QUO_LO, 8);
    read_word(OFF_REM_LO, 8);
    read_word(OFF_CTRL_LO, 2);
  endtask

  task automatic run_root(input logic wide, input logic [63:0] x);
    write_word(OFF_ROOT_OP, x, 8);
    send_access(ACC_WRITE, OFF_MODE, {7'($urandom), wide});
    read_word(OFF_ROOT_LO, 4);
  endtask

  // checker: done is sampled at the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result byte, expected none, actual %02h", $time, read_byte);
        error_count++;
      end else begin
        if (read_byte !== expected_bytes[0]) begin
          $display("%0t: read_byte mismatch, expected %02h, actual %02h",
                   $time, expected_bytes[0], read_byte);
          error_count++;
        end
        void'(expected_bytes.pop_front());
      end
    end
  end

  // directed corners: division edge cases, roots, whole map
  task automatic test_directed();
    send_idle_pct = 0;
    run_divide(MODE_32, 64'd100, 64'd7);
    run_divide(MODE_32, 64'hFFFF_FFFF_8000_0000, 64'hFFFF_FFFF);   // overflow
    run_divide(MODE_64_32, MIN64, 64'h0000_0000_FFFF_FFFF);         // overflow
    run_divide(MODE_64, MIN64, '1);                                 // overflow
    run_divide(MODE_32, 64'hFFFF_FFF0, 64'd0);                      // by zero
    run_divide(MODE_64_32, 64'd5, 64'h1_0000_0000);                 // zero low half
    run_divide(MODE_64, '1, 64'd0);
    run_divide(MODE_HOLD, 64'd9, 64'd3);
    run_divide(MODE_64, 64'h7FFF_FFFF_FFFF_FFFF, 64'd3);
    run_root(1'b1, '1);
    run_root(1'b0, '1);
    run_root(1'b1, 64'd0);
    // whole map, unmapped holes and writes to read-only bytes included
    for (int o = 0; o < 64; o++) send_access(ACC_WRITE, 6'(o), 8'($urandom));
    for (int o = 0; o < 64; o++) send_access(ACC_READ, 6'(o), 8'($urandom));
    drain();
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = v >> $urandom_range(63);
      1: v = -(v >> $urandom_range(63));
      2: v = MIN64 >> (32 * $urandom_range(1));
      3: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  // random well-formed sequences plus raw access noise
  task automatic test_random(input int idle_pct, input int items);
    int sent;
    send_idle_pct = idle_pct;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          run_divide(2'($urandom), rand_operand(),
                     ($urandom_range(7) == 0) ? 64'd0 : rand_operand());
          sent += 27;
        end
        4, 5: begin
          run_root(1'($urandom), rand_operand());
          sent += 13;
        end
        default: begin
          for (int i = 0; i < 8; i++) begin
            send_access(1'($urandom), 6'($urandom), 8'($urandom));
          end
          sent += 8;
        end
      endcase
    end
    drain();
  endtask

  initial begin
    error_count = 0;
    send_idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    op = ACC_READ;
    byte_offset = '0;
    write_byte = '0;
    ctrl_q = '0;
    numer_q = '0;
    denom_q = '0;
    quot_q = '0;
    rem_q = '0;
    rmode_q = 1'b0;
    rop_q = '0;
    root_q = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(0, 700);
    test_random(72, 500);
    test_random(22, 400);
    test_random(0, 400);
    drain();
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/dsru_pkg.sv
rtl/core/dsru_front.sv
rtl/core/dsru_back.sv
rtl/core/divide_sqrt_register_unit.sv
dv/testbench.sv
